// ===== rtl/core/oghd_pkg.sv =====
package oghd_pkg;

    // grid size defaults
    localparam int GRID_COLS_DEF = 64;
    localparam int GRID_ROWS_DEF = 64;

    // port widths fixed by the item fields
    localparam int COORD_W    = 16;
    localparam int IDX_OUT_W  = 6;
    localparam int OCC_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 3'd6;

    // item functions
    localparam logic FUNC_MARK  = 1'b0;
    localparam logic FUNC_SWEEP = 1'b1;

    // occupancy ceiling in percent
    localparam logic [OCC_W-1:0] OCC_MAX = 7'd100;

    // register reset values
    localparam logic [15:0] CELL_SIZE_RST   = 16'd51;
    localparam logic [6:0]  HIT_GAIN_RST    = 7'd60;
    localparam logic [6:0]  DECAY_STEP_RST  = 7'd10;
    localparam logic [5:0]  CENTER_COL_RST  = 6'd31;
    localparam logic [5:0]  CENTER_ROW_RST  = 6'd21;
    localparam logic [6:0]  COLS_IN_USE_RST = 7'd62;
    localparam logic [6:0]  ROWS_IN_USE_RST = 7'd42;

endpackage

// ===== rtl/core/occupancy_grid_hit_decay.sv =====
// occupancy grid in integer percent with per-scan hit marking and row decay.
// an item is taken on a clock edge with start high and busy low. a mark item
// (func 0) divides world_x and world_y by cell_size through one shared serial
// divider, one quotient bit per cycle, x first and then y, adds the centre cell
// and sets the hit bit of that cell when it lies inside the grid in use; it
// keeps busy high through 32 divide steps, an address state and a write state,
// and gives no result. a sweep item (func 1)
// walks one row through the single grid memory port, a read state and a write
// state per cell, and emits one cell per write state, last marking the final
// column; the last cell shows in the same cycle that busy falls. a sweep of a row
// outside the grid, or with no columns in use, does nothing and leaves busy low.
// each result is on cell_col, cell_row,
// occupancy and last for exactly one cycle while result_valid is high; the
// receiver cannot stall, so every result must be taken on that cycle. after
// reset a clearing pass zeroes all GRID_COLS * GRID_ROWS cells (4096 at the
// default size), one cell per cycle, with busy high;
// configuration writes are taken at any time but belong to idle periods.
module occupancy_grid_hit_decay #(
    parameter int GRID_COLS = oghd_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = oghd_pkg::GRID_ROWS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // item command
    input  logic                                start,
    output logic                                busy,
    input  logic                                func,
    input  logic signed [oghd_pkg::COORD_W-1:0] world_x,
    input  logic signed [oghd_pkg::COORD_W-1:0] world_y,
    input  logic [oghd_pkg::IDX_OUT_W-1:0]      sweep_row,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [oghd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [oghd_pkg::CFG_DATA_W-1:0]     cfg_data,
    // result strobe and payload
    output logic                                result_valid,
    output logic [oghd_pkg::IDX_OUT_W-1:0]      cell_col,
    output logic [oghd_pkg::IDX_OUT_W-1:0]      cell_row,
    output logic [oghd_pkg::OCC_W-1:0]          occupancy,
    output logic                                last
);
    import oghd_pkg::*;

    localparam int CELLS  = GRID_COLS * GRID_ROWS;
    localparam int AW     = $clog2(CELLS);
    localparam int CW     = $clog2(GRID_COLS);
    localparam int RW     = $clog2(GRID_ROWS);
    localparam int EC_W   = $clog2(GRID_COLS + 1);
    localparam int ER_W   = $clog2(GRID_ROWS + 1);
    localparam int QW     = COORD_W + 1;
    localparam int STEP_W = $clog2(COORD_W);
    localparam int SUM_W  = OCC_W + 2;

    // sequencer states
    localparam logic [2:0] ST_CLR     = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_DIV     = 3'd2;
    localparam logic [2:0] ST_MK_ADDR = 3'd3;
    localparam logic [2:0] ST_MK_WR   = 3'd4;
    localparam logic [2:0] ST_SW_RD   = 3'd5;
    localparam logic [2:0] ST_SW_WR   = 3'd6;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [15:0] cell_size_reg;
    logic [6:0]  hit_gain_reg;
    logic [6:0]  decay_step_reg;
    logic [5:0]  center_col_reg;
    logic [5:0]  center_row_reg;
    logic [6:0]  cols_in_use_reg;
    logic [6:0]  rows_in_use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg   <= CELL_SIZE_RST;
            hit_gain_reg    <= HIT_GAIN_RST;
            decay_step_reg  <= DECAY_STEP_RST;
            center_col_reg  <= CENTER_COL_RST;
            center_row_reg  <= CENTER_ROW_RST;
            cols_in_use_reg <= COLS_IN_USE_RST;
            rows_in_use_reg <= ROWS_IN_USE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CELL_SIZE:   cell_size_reg   <= cfg_data;
                REG_HIT_GAIN:    hit_gain_reg    <= cfg_data[6:0];
                REG_DECAY_STEP:  decay_step_reg  <= cfg_data[6:0];
                REG_CENTER_COL:  center_col_reg  <= cfg_data[5:0];
                REG_CENTER_ROW:  center_row_reg  <= cfg_data[5:0];
                REG_COLS_IN_USE: cols_in_use_reg <= cfg_data[6:0];
                REG_ROWS_IN_USE: rows_in_use_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // grid extent in use, limited to the physical grid
    logic [EC_W-1:0] eff_cols;
    logic [ER_W-1:0] eff_rows;

    always_comb
    begin
        if (int'(cols_in_use_reg) > GRID_COLS)
            eff_cols = EC_W'(GRID_COLS);
        else
            eff_cols = EC_W'(cols_in_use_reg);
        if (int'(rows_in_use_reg) > GRID_ROWS)
            eff_rows = ER_W'(GRID_ROWS);
        else
            eff_rows = ER_W'(rows_in_use_reg);
    end

    // ------------------------------------------------------------------
    // sequencer and datapath registers
    // ------------------------------------------------------------------
    logic [2:0]           state_reg, state_next;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;

    // serial divider
    logic [COORD_W-1:0]   divisor_reg, divisor_next;
    logic [COORD_W-1:0]   dvd_reg, dvd_next;
    logic [COORD_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic                 pass_y_reg, pass_y_next;
    logic [COORD_W-1:0]   ymag_reg, ymag_next;
    logic                 sx_reg, sx_next;
    logic                 sy_reg, sy_next;
    logic [COORD_W-1:0]   qx_reg, qx_next;
    logic [COORD_W-1:0]   qy_reg, qy_next;

    // mark write-back
    logic [AW-1:0]        mk_addr_reg, mk_addr_next;
    logic                 mk_in_reg, mk_in_next;

    // row sweep
    logic [AW-1:0]        sw_base_reg, sw_base_next;
    logic [CW-1:0]        sw_col_reg, sw_col_next;
    logic [IDX_OUT_W-1:0] sw_row_reg, sw_row_next;

    // result registers
    logic                 result_valid_reg, result_valid_next;
    logic [IDX_OUT_W-1:0] cell_col_reg, cell_col_next;
    logic [IDX_OUT_W-1:0] cell_row_reg, cell_row_next;
    logic [OCC_W-1:0]     occupancy_reg, occupancy_next;
    logic                 last_reg, last_next;

    // memory read data
    logic [OCC_W-1:0]     rd_occ_reg;
    logic                 rd_hit_reg;

    // memory port controls
    logic                 occ_we;
    logic                 hit_we;
    logic                 mem_re;
    logic [AW-1:0]        mem_addr;
    logic [OCC_W-1:0]     occ_wdata;
    logic                 hit_wdata;

    logic                 accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // shared divider step: restoring, one quotient bit per cycle
    // ------------------------------------------------------------------
    logic [COORD_W:0]   div_shift;
    logic               div_ge;
    logic [COORD_W:0]   div_diff;
    logic [COORD_W-1:0] div_rem;
    logic [COORD_W-1:0] div_q;

    always_comb
    begin
        div_shift = {rem_reg, dvd_reg[COORD_W-1]};
        div_ge    = (div_shift >= {1'b0, divisor_reg});
        div_diff  = div_shift - {1'b0, divisor_reg};
        div_rem   = div_ge ? div_diff[COORD_W-1:0] : div_shift[COORD_W-1:0];
        div_q     = {dvd_reg[COORD_W-2:0], div_ge};
    end

    // magnitudes of the incoming point; the most negative value maps to 2^15
    logic [COORD_W-1:0] xmag;
    logic [COORD_W-1:0] ymag;

    assign xmag = world_x[COORD_W-1] ? (COORD_W'(0) - world_x) : world_x;
    assign ymag = world_y[COORD_W-1] ? (COORD_W'(0) - world_y) : world_y;

    // ------------------------------------------------------------------
    // mark cell: signed quotient plus centre, bounds check, cell address
    // ------------------------------------------------------------------
    logic [QW-1:0] qx_ext;
    logic [QW-1:0] qy_ext;
    logic [QW-1:0] mk_col;
    logic [QW-1:0] mk_row;
    logic          mk_inside;
    logic [AW-1:0] mk_addr;

    always_comb
    begin
        qx_ext    = {1'b0, qx_reg};
        qy_ext    = {1'b0, qy_reg};
        mk_col    = (sx_reg ? (QW'(0) - qx_ext) : qx_ext) + QW'(center_col_reg);
        mk_row    = (sy_reg ? (QW'(0) - qy_ext) : qy_ext) + QW'(center_row_reg);
        mk_inside = !mk_col[QW-1] && (mk_col < QW'(eff_cols))
                 && !mk_row[QW-1] && (mk_row < QW'(eff_rows));
        mk_addr   = AW'(int'(mk_row[RW-1:0]) * GRID_COLS) + AW'(mk_col[CW-1:0]);
    end

    // ------------------------------------------------------------------
    // sweep cell update: decay, gain on hit, clamp to 0..100
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] sw_sum;
    logic [OCC_W-1:0] sw_occ;
    logic [AW-1:0]    sw_addr;
    logic             sw_last;

    always_comb
    begin
        sw_sum = SUM_W'(rd_occ_reg) - SUM_W'(decay_step_reg)
               + (rd_hit_reg ? SUM_W'(hit_gain_reg) : SUM_W'(0));
        if (sw_sum[SUM_W-1])
            sw_occ = '0;
        else if (sw_sum[SUM_W-2:0] > (SUM_W-1)'(OCC_MAX))
            sw_occ = OCC_MAX;
        else
            sw_occ = sw_sum[OCC_W-1:0];
        sw_addr = sw_base_reg + AW'(sw_col_reg);
        sw_last = (EC_W'(sw_col_reg) == (eff_cols - EC_W'(1)));
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        divisor_next      = divisor_reg;
        dvd_next          = dvd_reg;
        rem_next          = rem_reg;
        step_next         = step_reg;
        pass_y_next       = pass_y_reg;
        ymag_next         = ymag_reg;
        sx_next           = sx_reg;
        sy_next           = sy_reg;
        qx_next           = qx_reg;
        qy_next           = qy_reg;
        mk_addr_next      = mk_addr_reg;
        mk_in_next        = mk_in_reg;
        sw_base_next      = sw_base_reg;
        sw_col_next       = sw_col_reg;
        sw_row_next       = sw_row_reg;
        result_valid_next = 1'b0;
        cell_col_next     = cell_col_reg;
        cell_row_next     = cell_row_reg;
        occupancy_next    = occupancy_reg;
        last_next         = last_reg;

        occ_we    = 1'b0;
        hit_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = sw_addr;
        occ_wdata = sw_occ;
        hit_wdata = 1'b0;

        unique case (state_reg)
            ST_CLR:
            begin
                // zero one cell per cycle after reset
                occ_we    = 1'b1;
                hit_we    = 1'b1;
                mem_addr  = clr_addr_reg;
                occ_wdata = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(CELLS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_MARK)
                    begin
                        divisor_next = (cell_size_reg == '0) ? COORD_W'(1) : cell_size_reg;
                        dvd_next     = xmag;
                        rem_next     = '0;
                        step_next    = '0;
                        pass_y_next  = 1'b0;
                        ymag_next    = ymag;
                        sx_next      = world_x[COORD_W-1];
                        sy_next      = world_y[COORD_W-1];
                        state_next   = ST_DIV;
                    end
                    else if ((int'(sweep_row) < int'(eff_rows)) && (eff_cols != '0))
                    begin
                        sw_base_next = AW'(int'(sweep_row) * GRID_COLS);
                        sw_row_next  = sweep_row;
                        sw_col_next  = '0;
                        state_next   = ST_SW_RD;
                    end
                end
            end
            ST_DIV:
            begin
                dvd_next  = div_q;
                rem_next  = div_rem;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(COORD_W - 1))
                begin
                    if (!pass_y_reg)
                    begin
                        // x quotient done, start on y
                        qx_next     = div_q;
                        dvd_next    = ymag_reg;
                        rem_next    = '0;
                        pass_y_next = 1'b1;
                    end
                    else
                    begin
                        qy_next    = div_q;
                        state_next = ST_MK_ADDR;
                    end
                end
            end
            ST_MK_ADDR:
            begin
                mk_addr_next = mk_addr;
                mk_in_next   = mk_inside;
                state_next   = ST_MK_WR;
            end
            ST_MK_WR:
            begin
                // points outside the grid in use leave the map alone
                hit_we     = mk_in_reg;
                mem_addr   = mk_addr_reg;
                hit_wdata  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SW_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_SW_WR;
            end
            ST_SW_WR:
            begin
                occ_we            = 1'b1;
                hit_we            = 1'b1;
                result_valid_next = 1'b1;
                cell_col_next     = IDX_OUT_W'(sw_col_reg);
                cell_row_next     = sw_row_reg;
                occupancy_next    = sw_occ;
                last_next         = sw_last;
                sw_col_next       = sw_col_reg + CW'(1);
                if (sw_last)
                    state_next = ST_IDLE;
                else
                    state_next = ST_SW_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLR;
            clr_addr_reg     <= '0;
            step_reg         <= '0;
            pass_y_reg       <= 1'b0;
            mk_in_reg        <= 1'b0;
            sw_col_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            step_reg         <= step_next;
            pass_y_reg       <= pass_y_next;
            mk_in_reg        <= mk_in_next;
            sw_col_reg       <= sw_col_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        divisor_reg   <= divisor_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        ymag_reg      <= ymag_next;
        sx_reg        <= sx_next;
        sy_reg        <= sy_next;
        qx_reg        <= qx_next;
        qy_reg        <= qy_next;
        mk_addr_reg   <= mk_addr_next;
        sw_base_reg   <= sw_base_next;
        sw_row_reg    <= sw_row_next;
        cell_col_reg  <= cell_col_next;
        cell_row_reg  <= cell_row_next;
        occupancy_reg <= occupancy_next;
        last_reg      <= last_next;
    end

    // ------------------------------------------------------------------
    // grid memory: occupancy and hit bit per cell, one shared address
    // ------------------------------------------------------------------
    logic [OCC_W-1:0] occ_mem [CELLS];
    logic             hit_mem [CELLS];

    always_ff @(posedge clk)
    begin
        if (occ_we)
            occ_mem[mem_addr] <= occ_wdata;
        if (hit_we)
            hit_mem[mem_addr] <= hit_wdata;
        if (mem_re)
        begin
            rd_occ_reg <= occ_mem[mem_addr];
            rd_hit_reg <= hit_mem[mem_addr];
        end
    end

    // result ports
    assign result_valid = result_valid_reg;
    assign cell_col     = cell_col_reg;
    assign cell_row     = cell_row_reg;
    assign occupancy    = occupancy_reg;
    assign last         = last_reg;

endmodule

// ===== rtl/core/oghd_checker.sv =====
module oghd_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           busy,
    input logic                           result_valid,
    input logic [oghd_pkg::IDX_OUT_W-1:0] cell_col,
    input logic [oghd_pkg::IDX_OUT_W-1:0] cell_row,
    input logic [oghd_pkg::OCC_W-1:0]     occupancy,
    input logic                           last
);
    import oghd_pkg::*;

    // clearing pass holds the block busy through reset
    a_busy_in_reset: assert property (@(posedge clk) !rst_n |-> busy)
        else $error("busy low during reset");

    // occupancy stays within percent range
    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (occupancy <= OCC_MAX))
        else $error("occupancy above ceiling");

    // a row is still in progress after every cell but the last
    a_busy_mid_row: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> busy)
        else $error("idle with row unfinished");

    // between cells of a row result_valid drops, then the next column of the same row follows
    a_next_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> ##1 !result_valid ##1
        (result_valid && (cell_row == $past(cell_row, 2))
                      && (cell_col == $past(cell_col, 2) + 6'd1)))
        else $error("row cells out of sequence");

endmodule

bind occupancy_grid_hit_decay oghd_checker u_oghd_checker (.*);

// ===== tb/sv/occupancy_grid_hit_decay_test.sv =====
`timescale 1ns / 100ps

module occupancy_grid_hit_decay_test;

    import oghd_pkg::*;

    localparam int GRID_COLS  = GRID_COLS_DEF;
    localparam int GRID_ROWS  = GRID_ROWS_DEF;
    localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;

    // a mark holds busy through its divide, address and write states and gives
    // no result, so quiet time before a register write has to cover it
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 105;   // per phase, four phases
    localparam int MAX_REPORTS   = 10;

    // one emitted cell as seen on the result ports
    typedef struct packed {
        logic [IDX_OUT_W-1:0] col;
        logic [IDX_OUT_W-1:0] row;
        logic [OCC_W-1:0]     occ;
        logic                 last;
    } cell_result_t;

    // directed plan: register writes, marks and sweeps, with an occupancy
    // typed in for one column of a sweep where it is obvious by hand
    typedef enum logic [1:0] {STEP_REG, STEP_MARK, STEP_SWEEP} step_kind_t;

    typedef struct packed {
        step_kind_t            kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic signed [15:0]    x;
        logic signed [15:0]    y;
        logic [5:0]            row;
        logic                  pin;
        logic [5:0]            pin_col;
        logic [6:0]            pin_occ;
    } plan_step_t;

    localparam int PLAN_LEN = 38;

    localparam plan_step_t PLAN [0:PLAN_LEN-1] = '{
        // reset settings: cell 51, gain 60, decay 10, centre (31,21), 62 x 42
        '{STEP_MARK,  3'd0, 16'd0, 16'sd0, 16'sd0, 6'd0, 1'b0, 6'd0, 7'd0},
        // truncation toward zero lands -50,50 on the centre cell, counted once, and -51,-51 on (30,20)
        '{STEP_MARK,  3'd0, 16'd0, -16'sd50, 16'sd50, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_MARK,  3'd0, 16'd0, -16'sd51, -16'sd51, 6'd0, 1'b0, 6'd0, 7'd0},
        // coordinate extremes fall off the grid
        '{STEP_MARK,  3'd0, 16'd0, 16'sh7fff, 16'sh8000, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_MARK,  3'd0, 16'd0, 16'sh8000, 16'sh7fff, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_SWEEP, 3'd0, 16'd0, 16'sd0, 16'sd0, 6'd21, 1'b1, 6'd31, 7'd50},
        '{STEP_SWEEP, 3'd0, 16'd0, 16'sd0, 16'sd0, 6'd21, 1'b1, 6'd31, 7'd40},
        '{STEP_SWEEP, 3'd0, 16'd0, 16'sd0, 16'sd0, 6'd20, 1'b1, 6'd30, 7'd50},
        // rows past rows_in_use emit nothing
        '{STEP_SWEEP, 3'd0, 16'd0, 16'sd0, 16'sd0, 6'd42, 1'b0, 6'd0, 7'd0},
        '{STEP_SWEEP, 3'd0, 16'd0, 16'sd0, 16'sd0, 6'd63, 1'b0, 6'd0, 7'd0},
        // oversized column count acts as the full grid
        '{STEP_REG, REG_COLS_IN_USE, 16'd127, 16'sd0, 16'sd0, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_REG, REG_ROWS_IN_USE, 16'd64, 16'sd0, 16'sd0, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_REG, REG_HIT_GAIN, 16'd127, 16'sd0, 16'sd0, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_REG, REG_DECAY_STEP, 16'd0, 16'sd0, 16'sd0, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_MARK,  3'd0, 16'd0, 16'sd0, 16'sd0, 6'd0, 1'b0, 6'd0, 7'd0},
        // 40 + 127 clamps at the ceiling
        '{STEP_SWEEP, 3'd0, 16'd0, 16'sd0, 16'sd0, 6'd21, 1'b1, 6'd31, 7'd100},
        '{STEP_SWEEP, 3'd0, 16'd0, 16'sd0, 16'sd0, 6'd63, 1'b1, 6'd63, 7'd0},
        // zero cell size divides by one
        '{STEP_REG, REG_CELL_SIZE, 16'd0, 16'sd0, 16'sd0, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_REG, REG_CENTER_COL, 16'd0, 16'sd0, 16'sd0, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_REG, REG_CENTER_ROW, 16'd63, 16'sd0, 16'sd0, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_MARK,  3'd0, 16'd0, 16'sd63, 16'sd0, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_MARK,  3'd0, 16'd0, -16'sd1, 16'sd0, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_SWEEP, 3'd0, 16'd0, 16'sd0, 16'sd0, 6'd63, 1'b1, 6'd63, 7'd100},
        // largest cell size folds the whole world onto the centre
        '{STEP_REG, REG_CELL_SIZE, 16'hffff, 16'sd0, 16'sd0, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_REG, REG_CENTER_COL, 16'd63, 16'sd0, 16'sd0, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_REG, REG_CENTER_ROW, 16'd0, 16'sd0, 16'sd0, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_MARK,  3'd0, 16'd0, 16'sh7fff, 16'sh8000, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_MARK,  3'd0, 16'd0, 16'sh8000, 16'sh7fff, 6'd0, 1'b0, 6'd0, 7'd0},
        // decay above 100 drives everything to the floor
        '{STEP_REG, REG_DECAY_STEP, 16'd127, 16'sd0, 16'sd0, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_SWEEP, 3'd0, 16'd0, 16'sd0, 16'sd0, 6'd0, 1'b1, 6'd63, 7'd0},
        '{STEP_SWEEP, 3'd0, 16'd0, 16'sd0, 16'sd0, 6'd63, 1'b1, 6'd63, 7'd0},
        // empty grid: marks ignored, sweeps silent
        '{STEP_REG, REG_COLS_IN_USE, 16'd0, 16'sd0, 16'sd0, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_MARK,  3'd0, 16'd0, 16'sd0, 16'sd0, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_SWEEP, 3'd0, 16'd0, 16'sd0, 16'sd0, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_REG, REG_COLS_IN_USE, 16'd64, 16'sd0, 16'sd0, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_REG, REG_ROWS_IN_USE, 16'd0, 16'sd0, 16'sd0, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_SWEEP, 3'd0, 16'd0, 16'sd0, 16'sd0, 6'd0, 1'b0, 6'd0, 7'd0},
        '{STEP_MARK,  3'd0, 16'd0, 16'sd0, 16'sd0, 6'd0, 1'b0, 6'd0, 7'd0}
    };

    // sender idle percentage per random phase; the receiver cannot stall,
    // so phases 0 and 2 run the sender flat out and the shared phase uses 20
    int sender_idle_pct [4] = '{0, 57, 0, 20};

    logic clk = 1'b0;
    logic rst_n;

    logic                  start;
    logic                  busy;
    logic                  func;
    logic signed [15:0]    world_x;
    logic signed [15:0]    world_y;
    logic [5:0]            sweep_row;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  result_valid;
    logic [5:0]            cell_col;
    logic [5:0]            cell_row;
    logic [6:0]            occupancy;
    logic                  last;

    // mirror of the register file
    logic [15:0] grid_cell_size = CELL_SIZE_RST;
    logic [6:0]  grid_gain      = HIT_GAIN_RST;
    logic [6:0]  grid_decay     = DECAY_STEP_RST;
    logic [5:0]  grid_ccol      = CENTER_COL_RST;
    logic [5:0]  grid_crow      = CENTER_ROW_RST;
    logic [6:0]  grid_cols      = COLS_IN_USE_RST;
    logic [6:0]  grid_rows      = ROWS_IN_USE_RST;

    // mirror of both stores, zero like the clearing pass leaves them
    bit [6:0] occ_mirror [GRID_CELLS];
    bit       hit_mirror [GRID_CELLS];

    cell_result_t expected_cells [$];
    cell_result_t seen_cell;
    cell_result_t want_cell;
    int           mismatch_count = 0;

    occupancy_grid_hit_decay dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .world_x      (world_x),
        .world_y      (world_y),
        .sweep_row    (sweep_row),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .cell_col     (cell_col),
        .cell_row     (cell_row),
        .occupancy    (occupancy),
        .last         (last)
    );

    always #10 clk = ~clk;

    // apply one accepted item to the mirrored grid and queue the cells a
    // sweep emits; a typed-in occupancy replaces the computed one for its column
    function automatic void update_grid(input logic f, input logic signed [15:0] x,
                                        input logic signed [15:0] y, input logic [5:0] r,
                                        input logic pin, input logic [5:0] pin_col,
                                        input logic [6:0] pin_occ);
        int ncols;
        int nrows;
        int div;
        int col;
        int row;
        int idx;
        int v;
        cell_result_t emitted;
        ncols = (grid_cols > GRID_COLS) ? GRID_COLS : int'(grid_cols);
        nrows = (grid_rows > GRID_ROWS) ? GRID_ROWS : int'(grid_rows);
        if (f == FUNC_MARK)
        begin
            // signed divide truncates toward zero
            div = (grid_cell_size == 0) ? 1 : int'(grid_cell_size);
            col = int'(x) / div + int'(grid_ccol);
            row = int'(y) / div + int'(grid_crow);
            if (col >= 0 && col < ncols && row >= 0 && row < nrows)
                hit_mirror[row * GRID_COLS + col] = 1'b1;
        end
        else if (int'(r) < nrows)
        begin
            row = int'(r);
            for (col = 0; col < ncols; col++)
            begin
                idx = row * GRID_COLS + col;
                v = int'(occ_mirror[idx]) - int'(grid_decay);
                if (hit_mirror[idx])
                    v += int'(grid_gain);
                if (v < 0)
                    v = 0;
                if (v > int'(OCC_MAX))
                    v = int'(OCC_MAX);
                occ_mirror[idx] = v[6:0];
                hit_mirror[idx] = 1'b0;
                emitted.col  = col[5:0];
                emitted.row  = row[5:0];
                emitted.occ  = (pin && col == int'(pin_col)) ? pin_occ : v[6:0];
                emitted.last = (col == ncols - 1);
                expected_cells = {expected_cells, emitted};
            end
        end
    endfunction

    // present an item and hold it until the block takes it
    task automatic issue_item(input logic f, input logic signed [15:0] x,
                              input logic signed [15:0] y, input logic [5:0] r,
                              input logic pin, input logic [5:0] pin_col,
                              input logic [6:0] pin_occ);
        start     <= 1'b1;
        func      <= f;
        world_x   <= x;
        world_y   <= y;
        sweep_row <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // transfer happened at this edge
        update_grid(f, x, y, r, pin, pin_col, pin_occ);
    endtask

    // random sender gap after a transfer, geometric in length
    task automatic sender_gap(input int pct);
        if ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < pct)
                @(posedge clk);
        end
    endtask

    // drain every expected cell, then let a pending mark finish
    task automatic settle_grid();
        start <= 1'b0;
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // one register write, with a trailing wait so the enable never toggles within a step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        unique case (idx)
            REG_CELL_SIZE:   grid_cell_size = 16'(data);
            REG_HIT_GAIN:    grid_gain      = data[6:0];
            REG_DECAY_STEP:  grid_decay     = data[6:0];
            REG_CENTER_COL:  grid_ccol      = data[5:0];
            REG_CENTER_ROW:  grid_crow      = data[5:0];
            REG_COLS_IN_USE: grid_cols      = data[6:0];
            REG_ROWS_IN_USE: grid_rows      = data[6:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // result side: every strobe must match the oldest queued cell
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            seen_cell = '{col: cell_col, row: cell_row, occ: occupancy, last: last};
            if (expected_cells.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected cell: col %0d row %0d occ %0d last %0d",
                             cell_col, cell_row, occupancy, last);
            end
            else
            begin
                want_cell = expected_cells.pop_front();
                if (seen_cell != want_cell)
                begin
                    mismatch_count++;
                    // fields are col/row/occ/last
                    if (mismatch_count <= MAX_REPORTS)
                        $display("cell mismatch: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want_cell.col, want_cell.row, want_cell.occ, want_cell.last,
                                 cell_col, cell_row, occupancy, last);
                end
            end
        end
    end

    initial
    begin : stimulus
        int step;
        int phase;
        int item;
        int ncols;
        int nrows;
        int cs;
        int k;
        int off;
        int roll;
        logic f;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [5:0] r;

        rst_n     <= 1'b0;
        start     <= 1'b0;
        func      <= FUNC_MARK;
        world_x   <= '0;
        world_y   <= '0;
        sweep_row <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_CELL_SIZE;
        cfg_data  <= '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        // directed plan, back to back; the clearing pass just shows as busy
        for (step = 0; step < PLAN_LEN; step++)
        begin
            case (PLAN[step].kind)
                STEP_REG:
                begin
                    settle_grid();
                    write_reg(PLAN[step].idx, int'(PLAN[step].data));
                end
                STEP_MARK:
                    issue_item(FUNC_MARK, PLAN[step].x, PLAN[step].y, PLAN[step].row,
                               1'b0, 6'd0, 7'd0);
                default:
                    issue_item(FUNC_SWEEP, PLAN[step].x, PLAN[step].y, PLAN[step].row,
                               PLAN[step].pin, PLAN[step].pin_col, PLAN[step].pin_occ);
            endcase
        end

        // random phases, each with its own settings and sender behavior
        for (phase = 0; phase < 4; phase++)
        begin
            settle_grid();
            case (phase)
                0:
                begin
                    write_reg(REG_CELL_SIZE, $urandom_range(120, 20));
                    write_reg(REG_HIT_GAIN, $urandom_range(100));
                    write_reg(REG_DECAY_STEP, $urandom_range(100));
                    write_reg(REG_COLS_IN_USE, 64);
                    write_reg(REG_ROWS_IN_USE, 64);
                end
                1:
                begin
                    // finest grid, full gain, no decay
                    write_reg(REG_CELL_SIZE, 1);
                    write_reg(REG_HIT_GAIN, 100);
                    write_reg(REG_DECAY_STEP, 0);
                    write_reg(REG_COLS_IN_USE, $urandom_range(64, 1));
                    write_reg(REG_ROWS_IN_USE, $urandom_range(64, 1));
                end
                2:
                begin
                    // coarse cells, gain and decay anywhere in seven bits
                    write_reg(REG_CELL_SIZE, $urandom_range(65535, 1000));
                    write_reg(REG_HIT_GAIN, $urandom_range(127));
                    write_reg(REG_DECAY_STEP, $urandom_range(127));
                    write_reg(REG_COLS_IN_USE, $urandom_range(127, 65));
                    write_reg(REG_ROWS_IN_USE, $urandom_range(64, 1));
                end
                default:
                begin
                    write_reg(REG_CELL_SIZE, $urandom_range(300, 1));
                    write_reg(REG_HIT_GAIN, $urandom_range(60, 10));
                    write_reg(REG_DECAY_STEP, $urandom_range(30, 5));
                    write_reg(REG_COLS_IN_USE, $urandom_range(64, 1));
                    write_reg(REG_ROWS_IN_USE, $urandom_range(127, 65));
                end
            endcase
            write_reg(REG_CENTER_COL, $urandom_range(63));
            write_reg(REG_CENTER_ROW, $urandom_range(63));

            ncols = (grid_cols > GRID_COLS) ? GRID_COLS : int'(grid_cols);
            nrows = (grid_rows > GRID_ROWS) ? GRID_ROWS : int'(grid_rows);
            cs    = (grid_cell_size == 0) ? 1 : int'(grid_cell_size);

            for (item = 0; item < RANDOM_ITEMS; item++)
            begin
                roll = int'($urandom_range(99));
                x = 16'($urandom);
                y = 16'($urandom);
                r = 6'($urandom_range(63));
                if (roll < 55)
                begin
                    // aimed mark: pick a cell in use, place the point inside it
                    f   = FUNC_MARK;
                    k   = int'($urandom_range(ncols - 1)) - int'(grid_ccol);
                    off = int'($urandom_range(cs - 1));
                    if (k < 0 || (k == 0 && $urandom_range(1)))
                        off = -off;
                    x   = 16'(k * cs + off);
                    k   = int'($urandom_range(nrows - 1)) - int'(grid_crow);
                    off = int'($urandom_range(cs - 1));
                    if (k < 0 || (k == 0 && $urandom_range(1)))
                        off = -off;
                    y   = 16'(k * cs + off);
                end
                else if (roll < 80)
                begin
                    // sweep, mostly of a row in use
                    f = FUNC_SWEEP;
                    if ($urandom_range(99) < 85)
                        r = 6'($urandom_range(nrows - 1));
                end
                else
                    f = FUNC_MARK;   // stray point anywhere
                issue_item(f, x, y, r, 1'b0, 6'd0, 7'd0);
                sender_gap(sender_idle_pct[phase]);
            end
        end

        settle_grid();
        if (mismatch_count == 0 && expected_cells.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog: the clearing pass plus all full-row sweeps with long sender
    // gaps finish well inside this limit
    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
